// File: rtl/core/pva_pkg.sv
// Package for the polar vector adder: fixed-point constants, the CORDIC
// arctangent table, quadrant codes and the flag struct shared by the cells.
// No dependencies.
package pva_pkg;

  localparam int          GUARD_BITS         = 8;
  localparam logic [31:0] INV_GAIN           = 32'd2608131496;
  localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN          = 32'h8000_0000;
  localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  // Axis cases of the Cartesian sum, carried alongside the vectoring chain.
  typedef struct packed {
    logic x_zero;
    logic y_pos;
    logic y_neg;
  } pva_flags_t;

  // atan(2^-i) as a fraction of a full turn, 2^32 = full turn, truncated.
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h2000_0000;
      1:  v = 32'h12E4_051D;
      2:  v = 32'h09FB_385B;
      3:  v = 32'h0511_11D4;
      4:  v = 32'h028B_0D43;
      5:  v = 32'h0145_D7E1;
      6:  v = 32'h00A2_F61E;
      7:  v = 32'h0051_7C55;
      8:  v = 32'h0028_BE53;
      9:  v = 32'h0014_5F2E;
      10: v = 32'h000A_2F98;
      11: v = 32'h0005_17CC;
      12: v = 32'h0002_8BE6;
      13: v = 32'h0001_45F3;
      14: v = 32'h0000_A2F9;
      15: v = 32'h0000_517C;
      16: v = 32'h0000_28BE;
      17: v = 32'h0000_145F;
      18: v = 32'h0000_0A2F;
      19: v = 32'h0000_0517;
      20: v = 32'h0000_028B;
      21: v = 32'h0000_0145;
      22: v = 32'h0000_00A2;
      23: v = 32'h0000_0051;
      24: v = 32'h0000_0028;
      25: v = 32'h0000_0014;
      26: v = 32'h0000_000A;
      27: v = 32'h0000_0005;
      28: v = 32'h0000_0002;
      29: v = 32'h0000_0001;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/pva_rot_cell.sv
// One rotation-mode CORDIC micro-rotation for both input vectors.
// Depends on pva_pkg for the arctangent table.
module pva_rot_cell #(
  parameter int STAGE = 0,
  parameter int CW    = 28
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [CW-1:0] x1_i,
  input  logic signed [CW-1:0] y1_i,
  input  logic signed [31:0]   z1_i,
  input  logic [1:0]           q1_i,
  input  logic signed [CW-1:0] x2_i,
  input  logic signed [CW-1:0] y2_i,
  input  logic signed [31:0]   z2_i,
  input  logic [1:0]           q2_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [CW-1:0] x1_o,
  output logic signed [CW-1:0] y1_o,
  output logic signed [31:0]   z1_o,
  output logic [1:0]           q1_o,
  output logic signed [CW-1:0] x2_o,
  output logic signed [CW-1:0] y2_o,
  output logic signed [31:0]   z2_o,
  output logic [1:0]           q2_o
);
  import pva_pkg::*;

  localparam logic signed [31:0] Atan = atan_turn(STAGE);

  logic                 valid_q;
  logic signed [CW-1:0] x1_d, y1_d, x2_d, y2_d;
  logic signed [31:0]   z1_d, z2_d;
  logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [31:0]   z1_q, z2_q;
  logic [1:0]           q1_q, q2_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    if (!z1_i[31]) begin
      x1_d = x1_i - (y1_i >>> STAGE);
      y1_d = y1_i + (x1_i >>> STAGE);
      z1_d = z1_i - Atan;
    end else begin
      x1_d = x1_i + (y1_i >>> STAGE);
      y1_d = y1_i - (x1_i >>> STAGE);
      z1_d = z1_i + Atan;
    end
    if (!z2_i[31]) begin
      x2_d = x2_i - (y2_i >>> STAGE);
      y2_d = y2_i + (x2_i >>> STAGE);
      z2_d = z2_i - Atan;
    end else begin
      x2_d = x2_i + (y2_i >>> STAGE);
      y2_d = y2_i - (x2_i >>> STAGE);
      z2_d = z2_i + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      x1_q <= x1_d;
      y1_q <= y1_d;
      z1_q <= z1_d;
      q1_q <= q1_i;
      x2_q <= x2_d;
      y2_q <= y2_d;
      z2_q <= z2_d;
      q2_q <= q2_i;
    end
  end

  assign valid_o = valid_q;
  assign x1_o    = x1_q;
  assign y1_o    = y1_q;
  assign z1_o    = z1_q;
  assign q1_o    = q1_q;
  assign x2_o    = x2_q;
  assign y2_o    = y2_q;
  assign z2_o    = z2_q;
  assign q2_o    = q2_q;

endmodule

// File: rtl/core/pva_vec_cell.sv
// One vectoring-mode CORDIC micro-rotation of the Cartesian sum.
// Depends on pva_pkg for the arctangent table and the flag struct.
module pva_vec_cell #(
  parameter int STAGE = 0,
  parameter int CW    = 28
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic [31:0]          z_i,
  input  pva_pkg::pva_flags_t  flags_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic [31:0]          z_o,
  output pva_pkg::pva_flags_t  flags_o
);
  import pva_pkg::*;

  localparam logic [31:0] Atan = atan_turn(STAGE);

  logic                 valid_q;
  logic                 y_pos;
  logic signed [CW-1:0] x_d, y_d, x_q, y_q;
  logic [31:0]          z_d, z_q;
  pva_flags_t           flags_q;

  assign ready_o = !valid_q || ready_i;
  assign y_pos   = !y_i[CW-1] && (y_i != '0);

  always_comb begin
    if (y_pos) begin
      x_d = x_i + (y_i >>> STAGE);
      y_d = y_i - (x_i >>> STAGE);
      z_d = z_i + Atan;
    end else begin
      x_d = x_i - (y_i >>> STAGE);
      y_d = y_i + (x_i >>> STAGE);
      z_d = z_i - Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign flags_o = flags_q;

endmodule

// File: rtl/core/pva_gain.sv
// Two-stage multiply of a magnitude by the inverse CORDIC gain (Q0.32),
// rounding half up, with a side word carried along. Depends on pva_pkg.
module pva_gain #(
  parameter int MW = 33,
  parameter int SW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [MW-1:0] mag_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [MW-1:0] mag_o,
  output logic [SW-1:0] side_o
);
  import pva_pkg::*;

  localparam logic [64:0] RoundHalf = 65'd1 << 31;

  logic          a_valid_q, b_valid_q, b_ready;
  logic [63:0]   plo_d, plo_q;
  logic [MW-1:0] phi_d, phi_q;
  logic [SW-1:0] side_a_q, side_b_q;
  logic [64:0]   rnd;
  logic [MW:0]   sum;
  logic [MW-1:0] mag_q;

  assign b_ready = !b_valid_q || ready_i;
  assign ready_o = !a_valid_q || b_ready;

  // Split the magnitude at bit 32 to keep each product within 32 by 32.
  assign plo_d = 64'(mag_i[31:0]) * 64'(INV_GAIN);
  assign phi_d = MW'(mag_i[MW-1:32]) * MW'(INV_GAIN);

  assign rnd = {1'b0, plo_q} + RoundHalf;
  assign sum = {1'b0, phi_q} + (MW+1)'(rnd[64:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      plo_q    <= plo_d;
      phi_q    <= phi_d;
      side_a_q <= side_i;
    end
    if (b_ready) begin
      mag_q    <= sum[MW-1:0];
      side_b_q <= side_a_q;
    end
  end

  assign valid_o = b_valid_q;
  assign mag_o   = mag_q;
  assign side_o  = side_b_q;

endmodule

// File: rtl/core/polar_vector_add.sv
// Polar vector adder: sum of two (radius, angle) vectors in polar form.
// Depends on pva_pkg, pva_rot_cell, pva_vec_cell and pva_gain.
//
// Usage
//   Slave channel s_axis carries one request: two vectors, each a radius in
//   unsigned Q8.8 and an angle where 2^ANGLE_WIDTH is a full turn. Master
//   channel m_axis returns one result per request, in order: the radius of
//   the sum (one bit wider) and its angle in [0, full turn).
//   A request is taken on a rising edge with tvalid and tready both high.
// Pipeline
//   A result passes through, in order: a row of CORDIC_STAGES rotation
//   cells, the quadrant fix and add, the vectoring pre-rotation, a row of
//   CORDIC_STAGES vectoring cells, the axis fix-up, two two-stage gain
//   multipliers and the output register. One request is taken every
//   cycle unless a stall holds the row; each cell passes data on per cycle.
// Stall and reset
//   Every stage has a valid bit and moves when its successor is free, so
//   bubbles close up and a stalled receiver fills the row one stage at a
//   time; s_axis_tready drops only when every stage holds a request.
//   Reset clears all valid bits; nothing else is held across requests.
module polar_vector_add #(
  parameter int RADIUS_WIDTH  = 16,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16,
  localparam int InW  = ((2*RADIUS_WIDTH + 2*ANGLE_WIDTH + 7) / 8) * 8,
  localparam int OutW = ((RADIUS_WIDTH + 1 + ANGLE_WIDTH + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // fields from bit 0: first_radius, first_angle, second_radius, second_angle
  input  logic [InW-1:0]  s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // fields from bit 0: sum_radius, sum_angle
  output logic [OutW-1:0] m_axis_tdata
);
  import pva_pkg::*;

  localparam int RW   = RADIUS_WIDTH;
  localparam int AW   = ANGLE_WIDTH;
  localparam int N    = CORDIC_STAGES;
  // Coordinate width: radius, guard bits, room for gain and the sum, sign.
  localparam int CW   = RW + GUARD_BITS + 4;
  localparam int MagW = CW - 1;
  localparam int HiW  = (MagW > 32) ? (MagW - 32) : 1;
  localparam int MW   = 32 + HiW;
  localparam logic [32:0] AngRound = (33'd1 << (32 - AW)) >> 1;
  localparam logic [MW:0] RadRound = (MW+1)'(1) << (GUARD_BITS - 1);
  localparam logic [MW:0] RadMax   = (MW+1)'({(RW+1){1'b1}});

  // Unpack the request.
  logic [RW-1:0] first_radius, second_radius;
  logic [AW-1:0] first_angle, second_angle;
  logic [31:0]   turn1, turn2;

  assign first_radius  = s_axis_tdata[RW-1:0];
  assign first_angle   = s_axis_tdata[RW+AW-1:RW];
  assign second_radius = s_axis_tdata[2*RW+AW-1:RW+AW];
  assign second_angle  = s_axis_tdata[2*RW+2*AW-1:2*RW+AW];
  assign turn1         = 32'(first_angle) << (32 - AW);
  assign turn2         = 32'(second_angle) << (32 - AW);

  // Rotation row: index 0 is the start vector, index N the rotated one.
  logic                 rv [0:N];
  logic                 rr [0:N];
  logic signed [CW-1:0] rx1 [0:N];
  logic signed [CW-1:0] ry1 [0:N];
  logic signed [31:0]   rz1 [0:N];
  logic [1:0]           rq1 [0:N];
  logic signed [CW-1:0] rx2 [0:N];
  logic signed [CW-1:0] ry2 [0:N];
  logic signed [31:0]   rz2 [0:N];
  logic [1:0]           rq2 [0:N];

  assign rv[0]         = s_axis_tvalid;
  assign s_axis_tready = rr[0];
  // Start on the x axis with the residual angle below a quarter turn.
  assign rx1[0] = CW'({first_radius, {GUARD_BITS{1'b0}}});
  assign ry1[0] = '0;
  assign rz1[0] = {2'b00, turn1[29:0]};
  assign rq1[0] = turn1[31:30];
  assign rx2[0] = CW'({second_radius, {GUARD_BITS{1'b0}}});
  assign ry2[0] = '0;
  assign rz2[0] = {2'b00, turn2[29:0]};
  assign rq2[0] = turn2[31:30];

  for (genvar i = 0; i < N; i++) begin : g_rot
    pva_rot_cell #(
      .STAGE(i),
      .CW   (CW)
    ) u_rot (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(rv[i]),
      .ready_o(rr[i]),
      .x1_i   (rx1[i]),
      .y1_i   (ry1[i]),
      .z1_i   (rz1[i]),
      .q1_i   (rq1[i]),
      .x2_i   (rx2[i]),
      .y2_i   (ry2[i]),
      .z2_i   (rz2[i]),
      .q2_i   (rq2[i]),
      .valid_o(rv[i+1]),
      .ready_i(rr[i+1]),
      .x1_o   (rx1[i+1]),
      .y1_o   (ry1[i+1]),
      .z1_o   (rz1[i+1]),
      .q1_o   (rq1[i+1]),
      .x2_o   (rx2[i+1]),
      .y2_o   (ry2[i+1]),
      .z2_o   (rz2[i+1]),
      .q2_o   (rq2[i+1])
    );
  end

  // Quadrant turn, then add the two Cartesian vectors.
  logic                 add_valid_q, add_ready;
  logic signed [CW-1:0] fx1, fy1, fx2, fy2;
  logic signed [CW-1:0] sx_d, sy_d, sx_q, sy_q;

  always_comb begin
    case (rq1[N])
      QUAD_SECOND: begin fx1 = -ry1[N]; fy1 =  rx1[N]; end
      QUAD_THIRD:  begin fx1 = -rx1[N]; fy1 = -ry1[N]; end
      QUAD_FOURTH: begin fx1 =  ry1[N]; fy1 = -rx1[N]; end
      default:     begin fx1 =  rx1[N]; fy1 =  ry1[N]; end
    endcase
    case (rq2[N])
      QUAD_SECOND: begin fx2 = -ry2[N]; fy2 =  rx2[N]; end
      QUAD_THIRD:  begin fx2 = -rx2[N]; fy2 = -ry2[N]; end
      QUAD_FOURTH: begin fx2 =  ry2[N]; fy2 = -rx2[N]; end
      default:     begin fx2 =  rx2[N]; fy2 =  ry2[N]; end
    endcase
    sx_d = fx1 + fx2;
    sy_d = fy1 + fy2;
  end

  // Vectoring row: index 0 is the pre-rotated sum.
  logic                 vv [0:N];
  logic                 vr [0:N];
  logic signed [CW-1:0] vx [0:N];
  logic signed [CW-1:0] vy [0:N];
  logic [31:0]          vz [0:N];
  pva_flags_t           vf [0:N];

  logic                 pre_ready;
  logic signed [CW-1:0] px_d, py_d, px_q, py_q;
  logic [31:0]          pz_d, pz_q;
  pva_flags_t           pf_d, pf_q;
  logic                 pre_valid_q;

  assign add_ready = !add_valid_q || pre_ready;
  assign pre_ready = !pre_valid_q || vr[0];

  // Fold the left half plane over and start the angle at a half turn there.
  always_comb begin
    if (sx_q[CW-1]) begin
      px_d = -sx_q;
      py_d = -sy_q;
      pz_d = HALF_TURN;
    end else begin
      px_d = sx_q;
      py_d = sy_q;
      pz_d = '0;
    end
    pf_d.x_zero = (sx_q == '0);
    pf_d.y_pos  = !sy_q[CW-1] && (sy_q != '0);
    pf_d.y_neg  = sy_q[CW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_valid_q <= 1'b0;
      pre_valid_q <= 1'b0;
    end else begin
      if (add_ready) begin
        add_valid_q <= rv[N];
      end
      if (pre_ready) begin
        pre_valid_q <= add_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_ready) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
    if (pre_ready) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      pf_q <= pf_d;
    end
  end

  assign rr[N] = add_ready;
  assign vv[0] = pre_valid_q;
  assign vx[0] = px_q;
  assign vy[0] = py_q;
  assign vz[0] = pz_q;
  assign vf[0] = pf_q;

  for (genvar i = 0; i < N; i++) begin : g_vec
    pva_vec_cell #(
      .STAGE(i),
      .CW   (CW)
    ) u_vec (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vv[i]),
      .ready_o(vr[i]),
      .x_i    (vx[i]),
      .y_i    (vy[i]),
      .z_i    (vz[i]),
      .flags_i(vf[i]),
      .valid_o(vv[i+1]),
      .ready_i(vr[i+1]),
      .x_o    (vx[i+1]),
      .y_o    (vy[i+1]),
      .z_o    (vz[i+1]),
      .flags_o(vf[i+1])
    );
  end

  // Axis fix-up: clamp the magnitude, force the exact axis angles, round
  // the angle to the output width.
  logic          post_valid_q, post_ready;
  logic [MW-1:0] mag_d, mag_q;
  logic [31:0]   ang32;
  logic [32:0]   ang_rnd;
  logic [AW-1:0] ang_d, ang_q;
  logic          g1_valid, g1_ready, g2_valid, g2_ready;
  logic [MW-1:0] g1_mag, g2_mag;
  logic [AW-1:0] g1_ang, g2_ang;

  always_comb begin
    if (!vx[N][CW-1] && (vx[N] != '0)) begin
      mag_d = MW'(vx[N][MagW-1:0]);
    end else begin
      mag_d = '0;
    end
    ang32 = vz[N];
    if (vf[N].x_zero) begin
      if (vf[N].y_pos) begin
        ang32 = QUARTER_TURN;
      end else if (vf[N].y_neg) begin
        ang32 = THREE_QUARTER_TURN;
      end else begin
        ang32 = '0;
        mag_d = '0;
      end
    end
    ang_rnd = {1'b0, ang32} + AngRound;
    ang_d   = ang_rnd[31 -: AW];
  end

  assign post_ready = !post_valid_q || g1_ready;
  assign vr[N]      = post_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_valid_q <= 1'b0;
    end else if (post_ready) begin
      post_valid_q <= vv[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (post_ready) begin
      mag_q <= mag_d;
      ang_q <= ang_d;
    end
  end

  // Remove the gain of both CORDIC passes, one multiply each.
  pva_gain #(
    .MW(MW),
    .SW(AW)
  ) u_gain_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(post_valid_q),
    .ready_o(g1_ready),
    .mag_i  (mag_q),
    .side_i (ang_q),
    .valid_o(g1_valid),
    .ready_i(g2_ready),
    .mag_o  (g1_mag),
    .side_o (g1_ang)
  );

  logic          out_valid_q, out_ready;

  pva_gain #(
    .MW(MW),
    .SW(AW)
  ) u_gain_vec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(g1_valid),
    .ready_o(g2_ready),
    .mag_i  (g1_mag),
    .side_i (g1_ang),
    .valid_o(g2_valid),
    .ready_i(out_ready),
    .mag_o  (g2_mag),
    .side_o (g2_ang)
  );

  // Drop the guard bits with rounding, saturate, hold for the receiver.
  logic [MW:0]   rad_sum, rad_shift;
  logic [RW:0]   rad_d, rad_q;
  logic [AW-1:0] out_ang_q;

  assign out_ready = !out_valid_q || m_axis_tready;
  assign rad_sum   = {1'b0, g2_mag} + RadRound;
  assign rad_shift = rad_sum >> GUARD_BITS;
  assign rad_d     = (rad_shift > RadMax) ? RadMax[RW:0] : rad_shift[RW:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= g2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      rad_q     <= rad_d;
      out_ang_q <= g2_ang;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({out_ang_q, rad_q});

endmodule

// File: rtl/core/pva_checker.sv
// Port-level checks for polar_vector_add: reset, hold under stall and
// request accounting against the pipeline depth. Bound to the top level.
module pva_checker #(
  parameter int CORDIC_STAGES = 16,
  parameter int OUT_W         = 40
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam int Depth = 2 * CORDIC_STAGES + 8;

  logic       in_acc, out_acc;
  logic [7:0] count_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Track requests in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> count_q != 8'd0)
    else $error("result without a request in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 8'(Depth))
    else $error("more requests in flight than pipeline stages");

endmodule

bind polar_vector_add pva_checker #(
  .CORDIC_STAGES(CORDIC_STAGES),
  .OUT_W        (OutW)
) u_pva_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
